// ===== src/ess_pkg.sv =====
package ess_pkg;

  // Default widths of the poll fields.
  localparam int unsigned DEF_TIME_WIDTH = 32;
  localparam int unsigned DEF_RPM_WIDTH  = 16;

  // Width of the configuration data word and of the rpm/timeout registers.
  localparam int unsigned CFG_WIDTH      = 16;
  localparam int unsigned ATTEMPT_WIDTH  = 8;
  localparam int unsigned CFG_IDX_WIDTH  = 3;

  // Register reset values.
  localparam logic [CFG_WIDTH-1:0]     RST_RPM_MINIMUM    = 16'd200;
  localparam logic [CFG_WIDTH-1:0]     RST_RPM_MAXIMUM    = 16'd2700;
  localparam logic [CFG_WIDTH-1:0]     RST_RPM_OVER_MARK  = 16'd2650;
  localparam logic [CFG_WIDTH-1:0]     RST_RPM_UNDER_MARK = 16'd2200;
  localparam logic [CFG_WIDTH-1:0]     RST_CRANK_TIMEOUT  = 16'd2000;
  localparam logic [ATTEMPT_WIDTH-1:0] RST_START_ATTEMPTS = 8'd1;

  typedef enum logic [2:0] {
    PH_INIT  = 3'd0,
    PH_START = 3'd1,
    PH_RUN   = 3'd2,
    PH_STOP  = 3'd3,
    PH_ERROR = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_UNDER = 2'd1,
    FAULT_OVER  = 2'd2
  } fault_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_RPM_MINIMUM    = 3'd0,
    REG_RPM_MAXIMUM    = 3'd1,
    REG_RPM_OVER_MARK  = 3'd2,
    REG_RPM_UNDER_MARK = 3'd3,
    REG_CRANK_TIMEOUT  = 3'd4,
    REG_START_ATTEMPTS = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_WIDTH-1:0]     rpm_minimum;
    logic [CFG_WIDTH-1:0]     rpm_maximum;
    logic [CFG_WIDTH-1:0]     rpm_over_mark;
    logic [CFG_WIDTH-1:0]     rpm_under_mark;
    logic [CFG_WIDTH-1:0]     crank_timeout_ms;
    logic [ATTEMPT_WIDTH-1:0] start_attempts;
  } cfg_t;

  // Supervisor control state; it is also the result of the last poll.
  typedef struct packed {
    phase_e                   phase;
    logic [ATTEMPT_WIDTH-1:0] attempts_left;
    logic                     start_armed;
    logic                     ign;
    logic                     fuel;
    logic                     starter;
    logic                     under_mark;
    logic                     over_mark;
    fault_e                   fault;
  } ctrl_t;

endpackage

// ===== src/engine_start_supervisor.sv =====
// Pipeline: a poll accepted into the input register moves on, as its step result,
//   into the control state, which is the result register; while a stalled result
//   fills the result slot, the poll waits in the input register.
// Throughput: one poll per cycle while the result channel is not stalled.
// Reset (rst_ni low, asynchronous): phase init, one attempt, relays off, marks and
//   fault cleared, registers at their defaults, both pipeline stages empty.
module engine_start_supervisor import ess_pkg::*; #(
  parameter int unsigned TIME_WIDTH = DEF_TIME_WIDTH,
  parameter int unsigned RPM_WIDTH  = DEF_RPM_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Poll channel.
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [TIME_WIDTH-1:0]    time_ms_i,
  input  logic [RPM_WIDTH-1:0]     engine_rpm_i,
  input  logic                     run_enable_i,
  input  logic                     clear_fault_i,
  // Result channel.
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               phase_out_o,
  output logic                     ignition_on_o,
  output logic                     fuel_on_o,
  output logic                     starter_on_o,
  output logic                     under_range_o,
  output logic                     over_range_o,
  output logic [1:0]               fault_code_o,
  // Configuration write channel.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index_i,
  input  logic [CFG_WIDTH-1:0]     cfg_data_i
);

  // The input register parts the two channels: while a result waits to be
  // taken, one more transaction can still be captured here.
  logic                  in_valid_q;
  logic [TIME_WIDTH-1:0] time_q;
  logic [RPM_WIDTH-1:0]  rpm_q;
  logic                  run_q, clr_q;

  logic in_accept, advance;

  // The control state doubles as the result register: it only changes when
  // a new result is loaded, so it always holds the result on offer.
  ctrl_t                 ctrl_q, ctrl_d;
  logic [TIME_WIDTH-1:0] stamp_q, stamp_d;
  logic                  out_valid_q;

  cfg_t cfg_q;

  // The staged poll moves on when the result slot is empty or being drained.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      time_q <= time_ms_i;
      rpm_q  <= engine_rpm_i;
      run_q  <= run_enable_i;
      clr_q  <= clear_fault_i;
    end
  end

  ess_step #(
    .TIME_WIDTH(TIME_WIDTH),
    .RPM_WIDTH (RPM_WIDTH)
  ) u_step (
    .cfg_i        (cfg_q),
    .ctrl_i       (ctrl_q),
    .stamp_i      (stamp_q),
    .time_ms_i    (time_q),
    .engine_rpm_i (rpm_q),
    .run_enable_i (run_q),
    .clear_fault_i(clr_q),
    .ctrl_o       (ctrl_d),
    .stamp_o      (stamp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '{phase:         PH_INIT,
                  attempts_left: RST_START_ATTEMPTS,
                  start_armed:   1'b0,
                  ign:           1'b0,
                  fuel:          1'b0,
                  starter:       1'b0,
                  under_mark:    1'b0,
                  over_mark:     1'b0,
                  fault:         FAULT_NONE};
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        ctrl_q  <= ctrl_d;
        stamp_q <= stamp_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Configuration is always taken; indexes past the last register are ignored.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rpm_minimum:      RST_RPM_MINIMUM,
                 rpm_maximum:      RST_RPM_MAXIMUM,
                 rpm_over_mark:    RST_RPM_OVER_MARK,
                 rpm_under_mark:   RST_RPM_UNDER_MARK,
                 crank_timeout_ms: RST_CRANK_TIMEOUT,
                 start_attempts:   RST_START_ATTEMPTS};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_RPM_MINIMUM:    cfg_q.rpm_minimum      <= cfg_data_i;
        REG_RPM_MAXIMUM:    cfg_q.rpm_maximum      <= cfg_data_i;
        REG_RPM_OVER_MARK:  cfg_q.rpm_over_mark    <= cfg_data_i;
        REG_RPM_UNDER_MARK: cfg_q.rpm_under_mark   <= cfg_data_i;
        REG_CRANK_TIMEOUT:  cfg_q.crank_timeout_ms <= cfg_data_i;
        REG_START_ATTEMPTS: cfg_q.start_attempts   <= cfg_data_i[ATTEMPT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Result fields come straight from the control state.
  assign out_valid_o   = out_valid_q;
  assign phase_out_o   = ctrl_q.phase;
  assign ignition_on_o = ctrl_q.ign;
  assign fuel_on_o     = ctrl_q.fuel;
  assign starter_on_o  = ctrl_q.starter;
  assign under_range_o = ctrl_q.under_mark;
  assign over_range_o  = ctrl_q.over_mark;
  assign fault_code_o  = ctrl_q.fault;

endmodule

// ===== src/ess_step.sv =====
module ess_step import ess_pkg::*; #(
  parameter int unsigned TIME_WIDTH = DEF_TIME_WIDTH,
  parameter int unsigned RPM_WIDTH  = DEF_RPM_WIDTH
) (
  input  cfg_t                  cfg_i,
  input  ctrl_t                 ctrl_i,
  input  logic [TIME_WIDTH-1:0] stamp_i,
  input  logic [TIME_WIDTH-1:0] time_ms_i,
  input  logic [RPM_WIDTH-1:0]  engine_rpm_i,
  input  logic                  run_enable_i,
  input  logic                  clear_fault_i,
  output ctrl_t                 ctrl_o,
  output logic [TIME_WIDTH-1:0] stamp_o
);

  localparam int unsigned CW = (RPM_WIDTH > CFG_WIDTH) ? RPM_WIDTH : CFG_WIDTH;

  logic [CW-1:0]         rpm_ext, min_ext, max_ext, over_ext, under_ext;
  logic [TIME_WIDTH-1:0] timeout_ext, elapsed;
  logic [TIME_WIDTH:0]   twice_timeout;
  logic                  ahead, expired;
  ctrl_t                 n;
  logic [TIME_WIDTH-1:0] stamp_n;

  assign rpm_ext       = CW'(engine_rpm_i);
  assign min_ext       = CW'(cfg_i.rpm_minimum);
  assign max_ext       = CW'(cfg_i.rpm_maximum);
  assign over_ext      = CW'(cfg_i.rpm_over_mark);
  assign under_ext     = CW'(cfg_i.rpm_under_mark);
  assign timeout_ext   = TIME_WIDTH'(cfg_i.crank_timeout_ms);
  assign twice_timeout = {1'b0, timeout_ext} << 1;

  // Crank timing uses the stamp as it stands after a possible fresh arm.
  always_comb begin
    n       = ctrl_i;
    stamp_n = stamp_i;
    if ((ctrl_i.phase == PH_START) && (ctrl_i.attempts_left != '0) && run_enable_i &&
        !ctrl_i.start_armed) begin
      n.ign         = 1'b1;
      n.fuel        = 1'b1;
      n.starter     = 1'b1;
      n.start_armed = 1'b1;
      stamp_n       = time_ms_i;
    end
  end

  assign ahead   = time_ms_i > stamp_n;
  assign elapsed = ahead ? (time_ms_i - stamp_n) : '0;
  assign expired = ahead && (elapsed > timeout_ext);

  always_comb begin
    ctrl_o  = n;
    stamp_o = stamp_n;
    case (ctrl_i.phase)
      PH_START: begin
        if (ctrl_i.attempts_left != '0) begin
          if (n.start_armed) begin
            if (expired) begin
              ctrl_o.starter = 1'b0;
              if ({1'b0, elapsed} > twice_timeout) begin
                ctrl_o.attempts_left = ctrl_i.attempts_left - 8'd1;
                ctrl_o.start_armed   = 1'b0;
              end
            end else if ((!ahead || (elapsed < timeout_ext)) && (rpm_ext > min_ext)) begin
              ctrl_o.starter = 1'b0;
              ctrl_o.phase   = PH_RUN;
            end
          end
        end else begin
          ctrl_o.starter = 1'b0;
          ctrl_o.ign     = 1'b0;
          ctrl_o.fuel    = 1'b0;
          ctrl_o.phase   = PH_ERROR;
        end
        if (!run_enable_i) begin
          ctrl_o.starter = 1'b0;
          ctrl_o.ign     = 1'b0;
          ctrl_o.fuel    = 1'b0;
          ctrl_o.phase   = PH_STOP;
        end
      end
      PH_RUN: begin
        if (run_enable_i) begin
          if (rpm_ext < min_ext) begin
            ctrl_o.fault = FAULT_UNDER;
            ctrl_o.phase = PH_ERROR;
          end else if (rpm_ext > max_ext) begin
            ctrl_o.fault = FAULT_OVER;
            ctrl_o.phase = PH_ERROR;
          end else if (rpm_ext < under_ext) begin
            ctrl_o.under_mark = 1'b1;
          end else if (rpm_ext > over_ext) begin
            ctrl_o.over_mark = 1'b1;
          end else begin
            ctrl_o.under_mark = 1'b0;
            ctrl_o.over_mark  = 1'b0;
          end
        end else begin
          ctrl_o.phase = PH_STOP;
        end
      end
      PH_STOP: begin
        ctrl_o.starter = 1'b0;
        ctrl_o.ign     = 1'b0;
        ctrl_o.fuel    = 1'b0;
        if (run_enable_i) begin
          ctrl_o.phase = PH_START;
        end
      end
      PH_ERROR: begin
        if (clear_fault_i) begin
          ctrl_o.phase = PH_INIT;
        end
      end
      default: begin
        // Init, and any unreachable phase code, reloads the attempt budget.
        ctrl_o.attempts_left = cfg_i.start_attempts;
        ctrl_o.start_armed   = 1'b0;
        if (run_enable_i) begin
          if (rpm_ext > min_ext) begin
            ctrl_o.phase = PH_RUN;
          end else if (rpm_ext == '0) begin
            ctrl_o.phase = PH_START;
          end else begin
            ctrl_o.phase = PH_INIT;
          end
        end else begin
          ctrl_o.phase = PH_STOP;
        end
      end
    endcase
  end

endmodule

// ===== src/ess_checker.sv =====
module ess_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] phase_out_o,
  input logic       ignition_on_o,
  input logic       fuel_on_o,
  input logic       starter_on_o,
  input logic [1:0] fault_code_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its phase and starter level.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(phase_out_o) && $stable(starter_on_o))
    else $error("stalled result changed");

  // The starter is only ever driven with the ignition on.
  a_starter_ign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !starter_on_o || ignition_on_o)
    else $error("starter on without ignition");

  // Ignition and fuel valve switch together.
  a_fuel_ign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fuel_on_o == ignition_on_o)
    else $error("fuel valve and ignition disagree");

  // A recorded fault is never cleared.
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_code_o != 2'd0 |=> fault_code_o != 2'd0)
    else $error("fault code cleared");

endmodule

bind engine_start_supervisor ess_checker u_ess_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .phase_out_o  (phase_out_o),
  .ignition_on_o(ignition_on_o),
  .fuel_on_o    (fuel_on_o),
  .starter_on_o (starter_on_o),
  .fault_code_o (fault_code_o)
);
